>>> rtl/ck_pkg.sv
// ----------------------------------------------------------------------------
// ck_pkg
// Shared types and constants for the chroma key pixel pipeline.
// ----------------------------------------------------------------------------
package ck_pkg;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
        logic [7:0] pixel_alpha;
        logic       end_of_frame;
    } pixel_in_t;

    typedef struct packed {
        logic [7:0] result_red;
        logic [7:0] result_green;
        logic [7:0] result_blue;
        logic [7:0] result_alpha;
        logic       frame_last;
    } pixel_out_t;

    // register indexes
    typedef enum logic [2:0] {
        REG_KEY_RED   = 3'd0,
        REG_KEY_GREEN = 3'd1,
        REG_KEY_BLUE  = 3'd2,
        REG_THRESHOLD = 3'd3,
        REG_SOFTNESS  = 3'd4,
        REG_SPILL     = 3'd5
    } reg_idx_t;

    localparam int ADDR_W     = 5;
    localparam int NUM_STAGES = 12;
    localparam int SQ_W       = 18;
    localparam int ROOT_W     = 9;

    localparam logic [7:0] KEY_RED_RST   = 8'd0;
    localparam logic [7:0] KEY_GREEN_RST = 8'd255;
    localparam logic [7:0] KEY_BLUE_RST  = 8'd0;
    localparam logic [8:0] THRESHOLD_RST = 9'd102;
    localparam logic [8:0] SOFTNESS_RST  = 9'd26;
    localparam logic [8:0] SPILL_RST     = 9'd128;

    // distance scale 25600/44167 via reciprocal 97243/2^32
    localparam logic [23:0] DIST_MUL  = 24'd25600;
    localparam logic [40:0] DIST_RECIP = 41'd2489420800;
    localparam logic [23:0] DIST_DIV  = 24'd44167;

endpackage

>>> rtl/ck_isqrt.sv
// ----------------------------------------------------------------------------
// ck_isqrt
// Three stage integer square root, three digit steps per stage.
// ----------------------------------------------------------------------------
module ck_isqrt (
    input  logic                          aclk,
    input  logic [2:0]                    en,
    input  logic [ck_pkg::SQ_W-1:0]       sq_in,
    output logic [ck_pkg::ROOT_W-1:0]     root_out
);

    logic [ck_pkg::SQ_W-1:0] v_reg    [3];
    logic [ck_pkg::SQ_W-1:0] root_reg [3];
    logic [ck_pkg::SQ_W-1:0] v_next   [3];
    logic [ck_pkg::SQ_W-1:0] root_next[3];

    always_comb begin
        logic [ck_pkg::SQ_W-1:0] v;
        logic [ck_pkg::SQ_W-1:0] root;
        logic [ck_pkg::SQ_W-1:0] bitv;
        for (int s = 0; s < 3; s++) begin
            v    = (s == 0) ? sq_in : v_reg[(s == 0) ? 0 : s - 1];
            root = (s == 0) ? '0 : root_reg[(s == 0) ? 0 : s - 1];
            for (int j = 0; j < 3; j++) begin
                bitv = ck_pkg::SQ_W'(1) << (16 - 2 * (3 * s + j));
                if (v >= root + bitv) begin
                    v    = v - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
            end
            v_next[s]    = v;
            root_next[s] = root;
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < 3; s++) begin
            if (en[s]) begin
                v_reg[s]    <= v_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root_out = root_reg[2][ck_pkg::ROOT_W-1:0];

endmodule

>>> rtl/chroma_key_pixel.sv
// ----------------------------------------------------------------------------
// chroma_key_pixel
// Keys RGBA8 pixels against a key color with soft edge and spill suppression.
// ----------------------------------------------------------------------------
// throughput: one pixel per cycle while the output is not stalled, each stage has its own valid and stall
// the ramp divider (8 quotient bits over two stages) and the square root
// (9 steps over three stages) set the pipeline depth
// reset: synchronous active-low, clears valid bits and loads register defaults
module chroma_key_pixel (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  ck_pkg::pixel_in_t        s_data,
    output logic                     m_valid,
    input  logic                     m_ready,
    output ck_pkg::pixel_out_t       m_data,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ck_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int NS = ck_pkg::NUM_STAGES;

    // configuration
    logic [7:0] key_red_reg, key_green_reg, key_blue_reg;
    logic [8:0] threshold_reg, softness_reg, spill_reg;
    ck_pkg::reg_idx_t reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = ck_pkg::reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_red_reg   <= ck_pkg::KEY_RED_RST;
            key_green_reg <= ck_pkg::KEY_GREEN_RST;
            key_blue_reg  <= ck_pkg::KEY_BLUE_RST;
            threshold_reg <= ck_pkg::THRESHOLD_RST;
            softness_reg  <= ck_pkg::SOFTNESS_RST;
            spill_reg     <= ck_pkg::SPILL_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                ck_pkg::REG_KEY_RED:   key_red_reg   <= pwdata[7:0];
                ck_pkg::REG_KEY_GREEN: key_green_reg <= pwdata[7:0];
                ck_pkg::REG_KEY_BLUE:  key_blue_reg  <= pwdata[7:0];
                ck_pkg::REG_THRESHOLD: threshold_reg <= pwdata[8:0];
                ck_pkg::REG_SOFTNESS:  softness_reg  <= pwdata[8:0];
                ck_pkg::REG_SPILL:     spill_reg     <= pwdata[8:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ck_pkg::REG_KEY_RED:   prdata = {24'd0, key_red_reg};
            ck_pkg::REG_KEY_GREEN: prdata = {24'd0, key_green_reg};
            ck_pkg::REG_KEY_BLUE:  prdata = {24'd0, key_blue_reg};
            ck_pkg::REG_THRESHOLD: prdata = {23'd0, threshold_reg};
            ck_pkg::REG_SOFTNESS:  prdata = {23'd0, softness_reg};
            ck_pkg::REG_SPILL:     prdata = {23'd0, spill_reg};
            default:               prdata = 32'd0;
        endcase
    end

    // spill channel select
    logic sel_g, sel_b;
    assign sel_g = (key_green_reg > key_red_reg) && (key_green_reg > key_blue_reg);
    assign sel_b = !sel_g && (key_blue_reg > key_red_reg) && (key_blue_reg > key_green_reg);

    // pipeline control
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] en;
    ck_pkg::pixel_in_t pix_reg [NS];

    always_comb begin
        en[NS-1] = !vld_reg[NS-1] || m_ready;
        for (int k = NS - 2; k >= 0; k--) begin
            en[k] = !vld_reg[k] || en[k+1];
        end
    end

    assign s_ready = en[0];
    assign m_valid = vld_reg[NS-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pix_reg[0] <= s_data;
        end
        for (int k = 1; k < NS; k++) begin
            if (en[k]) begin
                pix_reg[k] <= pix_reg[k-1];
            end
        end
    end

    // stage 0: squared distance, luma excess
    logic signed [8:0]  dr, dg, db;
    logic signed [17:0] pr, pg, pb;
    logic [15:0]        luma;
    logic [7:0]         chs;
    logic signed [17:0] exc_s;
    logic [17:0]        sq_reg;
    logic [15:0]        exc_reg;

    always_comb begin
        dr    = $signed({1'b0, s_data.pixel_red})   - $signed({1'b0, key_red_reg});
        dg    = $signed({1'b0, s_data.pixel_green}) - $signed({1'b0, key_green_reg});
        db    = $signed({1'b0, s_data.pixel_blue})  - $signed({1'b0, key_blue_reg});
        pr    = 18'(dr * dr);
        pg    = 18'(dg * dg);
        pb    = 18'(db * db);
        luma  = 16'(16'(s_data.pixel_red) * 16'd77) + 16'(16'(s_data.pixel_green) * 16'd150)
              + 16'(16'(s_data.pixel_blue) * 16'd29);
        chs   = sel_g ? s_data.pixel_green : s_data.pixel_blue;
        exc_s = $signed({2'b00, chs, 8'h00}) - $signed({2'b00, luma});
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            sq_reg  <= $unsigned(pr) + $unsigned(pg) + $unsigned(pb);
            exc_reg <= ((sel_g || sel_b) && exc_s > 0) ? exc_s[15:0] : 16'd0;
        end
    end

    // stages 1 to 3: square root, spill product carried alongside
    logic [ck_pkg::ROOT_W-1:0] root;
    logic [24:0] es_reg [1:7];

    ck_isqrt u_isqrt (
        .aclk     (aclk),
        .en       (en[3:1]),
        .sq_in    (sq_reg),
        .root_out (root)
    );

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            es_reg[1] <= 25'(exc_reg) * 25'(spill_reg);
        end
        for (int k = 2; k <= 7; k++) begin
            if (en[k]) begin
                es_reg[k] <= es_reg[k-1];
            end
        end
    end

    // stage 4: distance scaling products
    logic [23:0] x_reg;
    logic [40:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            x_reg <= 24'(root) * ck_pkg::DIST_MUL;
            p_reg <= 41'(root) * ck_pkg::DIST_RECIP;
        end
    end

    // stage 5: quotient correction
    logic [7:0]  q0;
    logic [23:0] rem;
    logic [7:0]  dist_reg;

    assign q0  = p_reg[39:32];
    assign rem = x_reg - 24'(24'(q0) * ck_pkg::DIST_DIV);

    always_ff @(posedge aclk) begin
        if (en[5]) begin
            dist_reg <= (rem >= ck_pkg::DIST_DIV) ? q0 + 8'd1 : q0;
        end
    end

    // stage 6: ramp classification, upper quotient bits
    logic signed [10:0] lo;
    logic [9:0]         hi;
    logic               below, ramp;
    logic [10:0]        n_full;
    logic [9:0]         r6;
    logic [9:0]         t6;
    logic [3:0]         q6;
    logic               below_reg, ramp_reg;
    logic [8:0]         r_reg;
    logic [3:0]         qh_reg;

    always_comb begin
        lo     = $signed({2'b00, threshold_reg}) - $signed({2'b00, softness_reg});
        hi     = 10'(threshold_reg) + 10'(softness_reg);
        below  = $signed({3'b000, dist_reg}) < lo;
        ramp   = !below && (10'(dist_reg) < hi);
        n_full = 11'(dist_reg) - $unsigned(lo);
        q6[3]  = n_full[9:0] >= 10'(softness_reg);
        r6     = q6[3] ? n_full[9:0] - 10'(softness_reg) : n_full[9:0];
        for (int i = 2; i >= 0; i--) begin
            t6    = {r6[8:0], 1'b0};
            q6[i] = t6 >= 10'(softness_reg);
            r6    = q6[i] ? t6 - 10'(softness_reg) : t6;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[6]) begin
            below_reg <= below;
            ramp_reg  <= ramp;
            r_reg     <= r6[8:0];
            qh_reg    <= q6;
        end
    end

    // stage 7: lower quotient bits, key alpha
    logic [9:0] r7;
    logic [9:0] t7;
    logic [3:0] q7;
    logic [8:0] alpha_reg;

    always_comb begin
        r7 = 10'(r_reg);
        for (int i = 3; i >= 0; i--) begin
            t7    = {r7[8:0], 1'b0};
            q7[i] = t7 >= 10'(softness_reg);
            r7    = q7[i] ? t7 - 10'(softness_reg) : t7;
        end
    end

    always_ff @(posedge aclk) begin
        if (en[7]) begin
            if (below_reg) begin
                alpha_reg <= 9'd0;
            end else if (ramp_reg) begin
                alpha_reg <= {1'b0, qh_reg, q7};
            end else begin
                alpha_reg <= 9'd256;
            end
        end
    end

    // stage 8: spill reduction and alpha scale
    logic [33:0] red_prod;
    logic [17:0] red_reg;
    logic [15:0] scale8_reg;

    assign red_prod = 34'(es_reg[7]) * 34'(9'd256 - alpha_reg);

    always_ff @(posedge aclk) begin
        if (en[8]) begin
            red_reg    <= red_prod[33:16];
            scale8_reg <= 16'(17'(alpha_reg) * 17'(pix_reg[7].pixel_alpha));
        end
    end

    // stage 9: spill-corrected channels
    logic [15:0] c_in [3];
    logic [15:0] c_reg [3];
    logic [15:0] scale9_reg;

    assign c_in[0] = {pix_reg[8].pixel_red, 8'h00};
    assign c_in[1] = {pix_reg[8].pixel_green, 8'h00};
    assign c_in[2] = {pix_reg[8].pixel_blue, 8'h00};

    always_ff @(posedge aclk) begin
        if (en[9]) begin
            for (int i = 0; i < 3; i++) begin
                if ((sel_g && i == 1) || (sel_b && i == 2)) begin
                    c_reg[i] <= (red_reg >= 18'(c_in[i])) ? 16'd0 : 16'(18'(c_in[i]) - red_reg);
                end else begin
                    c_reg[i] <= c_in[i];
                end
            end
            scale9_reg <= scale8_reg;
        end
    end

    // stage 10: premultiply
    logic [31:0] prod10 [3];
    logic [15:0] y_reg [3];
    logic [7:0]  ya_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            prod10[i] = 32'(c_reg[i]) * 32'(scale9_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (en[10]) begin
            for (int i = 0; i < 3; i++) begin
                y_reg[i] <= prod10[i][31:16];
            end
            ya_reg <= scale9_reg[15:8];
        end
    end

    // stage 11: divide by 255, saturate
    logic [16:0] d255 [3];
    logic [7:0]  o255 [3];
    ck_pkg::pixel_out_t out_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d255[i] = (17'(y_reg[i]) + 17'd1 + 17'(y_reg[i][15:8])) >> 8;
            o255[i] = (d255[i] > 17'd255) ? 8'd255 : d255[i][7:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en[11]) begin
            out_reg.result_red   <= o255[0];
            out_reg.result_green <= o255[1];
            out_reg.result_blue  <= o255[2];
            out_reg.result_alpha <= ya_reg;
            out_reg.frame_last   <= pix_reg[10].end_of_frame;
        end
    end

    assign m_data = out_reg;

endmodule

>>> rtl/ck_chk.sv
// ----------------------------------------------------------------------------
// ck_chk
// Port-level checks for chroma_key_pixel, bound to the top level.
// ----------------------------------------------------------------------------
module ck_chk (
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input ck_pkg::pixel_in_t         s_data,
    input logic                      m_valid,
    input logic                      m_ready,
    input ck_pkg::pixel_out_t        m_data,
    input logic                      psel,
    input logic                      penable,
    input logic                      pwrite,
    input logic [ck_pkg::ADDR_W-1:0] paddr,
    input logic [31:0]               pwdata,
    input logic [31:0]               prdata,
    input logic                      pready
);

    // result beat holds while stalled
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat dropped or changed under stall");

    // an empty or draining output never blocks the input
    a_no_block: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_ready || !m_valid) |-> s_ready)
        else $error("input stalled with free output");

    // zero alpha leaves no color
    a_zero_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.result_alpha == 8'd0 |->
            m_data.result_red == 8'd0 && m_data.result_green == 8'd0 &&
            m_data.result_blue == 8'd0)
        else $error("color without alpha");

    // no result is valid right after reset
    a_no_early: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result right after reset");

endmodule

bind chroma_key_pixel ck_chk u_ck_chk (.*);

>>> dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for chroma_key_pixel. A directed table of pixels
// runs first, then bursts of random pixels under several key settings, some
// near the key color and some anywhere. Register writes go through the APB
// port while the pipeline is empty. A predictor computes results not given
// by the table, and results are compared field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    typedef struct {
        ck_pkg::pixel_in_t  px;
        bit                 typed;
        ck_pkg::pixel_out_t res;
    } pixel_row_t;

    typedef struct {
        bit                 typed;
        ck_pkg::pixel_out_t res;
    } pending_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    ck_pkg::pixel_in_t  s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    ck_pkg::pixel_out_t m_data;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ck_pkg::ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned key_r, key_g, key_b, thresh, soft_w, spill;
    pending_t    beat_tags[$];
    ck_pkg::pixel_out_t keyed_pixels[$];
    int          mismatches = 0;
    int unsigned stall_mode = 0;
    int unsigned stall_cnt = 0;

    chroma_key_pixel i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int unsigned root_of(int unsigned v);
        int unsigned root = 0;
        int unsigned bitv = 1 << 30;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned clip255(longint unsigned v);
        return (v > 64'd255) ? 64'd255 : v;
    endfunction

    function automatic ck_pkg::pixel_out_t key_pixel(ck_pkg::pixel_in_t p);
        int dr, dg, db, dist_q, lo, hi, alpha, sel;
        longint unsigned c[3];
        longint luma, excess;
        longint unsigned cut, scale;
        ck_pkg::pixel_out_t o;
        dr = int'(p.pixel_red) - int'(key_r);
        dg = int'(p.pixel_green) - int'(key_g);
        db = int'(p.pixel_blue) - int'(key_b);
        dist_q = int'((root_of(dr * dr + dg * dg + db * db) * 25600) / 44167);
        lo = int'(thresh) - int'(soft_w);
        hi = int'(thresh) + int'(soft_w);
        if (dist_q < lo) begin
            alpha = 0;
        end else if (dist_q < hi) begin
            alpha = ((dist_q - lo) * 256) / (2 * int'(soft_w));
            if (alpha < 0) alpha = 0;
            if (alpha > 256) alpha = 256;
        end else begin
            alpha = 256;
        end
        c[0] = longint'(p.pixel_red) << 8;
        c[1] = longint'(p.pixel_green) << 8;
        c[2] = longint'(p.pixel_blue) << 8;
        sel = -1;
        if (key_g > key_r && key_g > key_b) sel = 1;
        else if (key_b > key_r && key_b > key_g) sel = 2;
        if (sel >= 0) begin
            luma = 64'sd77 * longint'(p.pixel_red) + 64'sd150 * longint'(p.pixel_green)
                 + 64'sd29 * longint'(p.pixel_blue);
            excess = longint'(c[sel]) - luma;
            if (excess > 0) begin
                cut = (64'(excess) * 64'(spill) * 64'(256 - alpha)) >> 16;
                c[sel] = (cut >= c[sel]) ? 64'd0 : c[sel] - cut;
            end
        end
        scale = 64'(alpha) * 64'(p.pixel_alpha);
        o.result_red   = 8'(clip255((c[0] * scale) / 64'd16711680));
        o.result_green = 8'(clip255((c[1] * scale) / 64'd16711680));
        o.result_blue  = 8'(clip255((c[2] * scale) / 64'd16711680));
        o.result_alpha = 8'(clip255(scale >> 8));
        o.frame_last   = p.end_of_frame;
        return o;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // input and result monitors
    always @(posedge aclk) begin
        pending_t   tag;
        ck_pkg::pixel_out_t want;
        if (aresetn && s_valid && s_ready) begin
            tag = beat_tags.pop_front();
            keyed_pixels.push_back(tag.typed ? tag.res : key_pixel(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (keyed_pixels.size() == 0) begin
                report_mismatch("unexpected beat", 1, 0);
            end else begin
                want = keyed_pixels.pop_front();
                if (m_data.result_red != want.result_red)
                    report_mismatch("red", int'(m_data.result_red),
                                    int'(want.result_red));
                if (m_data.result_green != want.result_green)
                    report_mismatch("green", int'(m_data.result_green),
                                    int'(want.result_green));
                if (m_data.result_blue != want.result_blue)
                    report_mismatch("blue", int'(m_data.result_blue),
                                    int'(want.result_blue));
                if (m_data.result_alpha != want.result_alpha)
                    report_mismatch("alpha", int'(m_data.result_alpha),
                                    int'(want.result_alpha));
                if (m_data.frame_last != want.frame_last)
                    report_mismatch("frame_last", int'(m_data.frame_last),
                                    int'(want.frame_last));
            end
        end
    end

    // receiver stall pattern
    always @(posedge aclk) begin
        if (stall_cnt == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_cnt  <= $urandom_range(8, 80);
        end else begin
            stall_cnt <= stall_cnt - 1;
        end
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 1) == 1);
            2: m_ready <= (stall_cnt[1:0] != 2'b00);
            default: m_ready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    task automatic write_reg(ck_pkg::reg_idx_t idx, int unsigned value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ck_pkg::REG_KEY_RED:   key_r  = value & 32'hff;
            ck_pkg::REG_KEY_GREEN: key_g  = value & 32'hff;
            ck_pkg::REG_KEY_BLUE:  key_b  = value & 32'hff;
            ck_pkg::REG_THRESHOLD: thresh = value & 32'h1ff;
            ck_pkg::REG_SOFTNESS:  soft_w = value & 32'h1ff;
            default:               spill  = value & 32'h1ff;
        endcase
    endtask

    // drives one beat, leaves valid high
    task automatic send_pixel(ck_pkg::pixel_in_t p, bit typed, ck_pkg::pixel_out_t res);
        pending_t tag;
        tag.typed = typed;
        tag.res   = res;
        beat_tags.push_back(tag);
        s_data  <= p;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_pipeline();
        s_valid <= 1'b0;
        while (keyed_pixels.size() != 0 || beat_tags.size() != 0) @(posedge aclk);
        repeat (ck_pkg::NUM_STAGES + 4) @(posedge aclk);
    endtask

    function automatic logic [7:0] near_key(int unsigned k);
        int v;
        v = int'(k) + int'($urandom_range(0, 120)) - 60;
        return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
    endfunction

    initial begin
        pixel_row_t  rows[12];
        int unsigned phase_cfg[7][6] = '{
            '{0, 255, 0, 102, 26, 128},
            '{0, 255, 0, 0, 0, 256},
            '{0, 0, 255, 256, 256, 0},
            '{255, 255, 255, 128, 0, 64},
            '{40, 200, 90, 60, 40, 200},
            '{255, 0, 0, 256, 0, 128},
            '{0, 0, 0, 0, 256, 256}
        };
        ck_pkg::pixel_in_t   p;
        ck_pkg::pixel_out_t  none;
        int          burst, gap;

        key_r = 32'(ck_pkg::KEY_RED_RST);
        key_g = 32'(ck_pkg::KEY_GREEN_RST);
        key_b = 32'(ck_pkg::KEY_BLUE_RST);
        thresh = 32'(ck_pkg::THRESHOLD_RST);
        soft_w = 32'(ck_pkg::SOFTNESS_RST);
        spill = 32'(ck_pkg::SPILL_RST);
        none = '0;

        rows[0]  = '{'{8'd0, 8'd255, 8'd0, 8'd255, 1'b0}, 1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}};
        rows[1]  = '{'{8'd255, 8'd0, 8'd255, 8'd255, 1'b1}, 1,
                     '{8'd255, 8'd0, 8'd255, 8'd255, 1'b1}};
        rows[2]  = '{'{8'd255, 8'd255, 8'd255, 8'd0, 1'b0}, 1, '{8'd0, 8'd0, 8'd0, 8'd0, 1'b0}};
        rows[3]  = '{'{8'd0, 8'd0, 8'd0, 8'd255, 1'b1}, 0, none};
        rows[4]  = '{'{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 0, none};
        rows[5]  = '{'{8'd60, 8'd200, 8'd50, 8'd255, 1'b0}, 0, none};
        rows[6]  = '{'{8'd20, 8'd180, 8'd30, 8'd128, 1'b0}, 0, none};
        rows[7]  = '{'{8'd100, 8'd220, 8'd90, 8'd255, 1'b0}, 0, none};
        rows[8]  = '{'{8'd170, 8'd85, 8'd170, 8'd85, 1'b1}, 0, none};
        rows[9]  = '{'{8'd85, 8'd170, 8'd85, 8'd170, 1'b0}, 0, none};
        rows[10] = '{'{8'd0, 8'd255, 8'd255, 8'd1, 1'b0}, 0, none};
        rows[11] = '{'{8'd40, 8'd160, 8'd0, 8'd254, 1'b1}, 0, none};

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_pixel(rows[i].px, rows[i].typed, rows[i].res);
        drain_pipeline();

        for (int ph = 0; ph < 7; ph++) begin
            write_reg(ck_pkg::REG_KEY_RED,   phase_cfg[ph][0]);
            write_reg(ck_pkg::REG_KEY_GREEN, phase_cfg[ph][1]);
            write_reg(ck_pkg::REG_KEY_BLUE,  phase_cfg[ph][2]);
            write_reg(ck_pkg::REG_THRESHOLD, phase_cfg[ph][3]);
            write_reg(ck_pkg::REG_SOFTNESS,  phase_cfg[ph][4]);
            write_reg(ck_pkg::REG_SPILL,     phase_cfg[ph][5]);
            for (int n = 0; n < 250; n += burst) begin
                burst = $urandom_range(1, 40);
                for (int k = 0; k < burst; k++) begin
                    if ($urandom_range(0, 9) < 6) begin
                        p.pixel_red   = near_key(key_r);
                        p.pixel_green = near_key(key_g);
                        p.pixel_blue  = near_key(key_b);
                    end else begin
                        p.pixel_red   = 8'($urandom_range(0, 255));
                        p.pixel_green = 8'($urandom_range(0, 255));
                        p.pixel_blue  = 8'($urandom_range(0, 255));
                    end
                    case ($urandom_range(0, 5))
                        0:       p.pixel_alpha = 8'd0;
                        1:       p.pixel_alpha = 8'd255;
                        default: p.pixel_alpha = 8'($urandom_range(0, 255));
                    endcase
                    p.end_of_frame = ($urandom_range(0, 7) == 0);
                    send_pixel(p, 1'b0, none);
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            drain_pipeline();
        end

        if (mismatches == 0 && keyed_pixels.size() == 0) begin
            $display("chroma_key_pixel test passed");
        end else begin
            $display("chroma_key_pixel test failed");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("chroma_key_pixel test failed");
        $finish;
    end

endmodule
